// ----- hdl/ube64_pkg.sv -----
// ----------------------------------------------------------------------------
// ube64_pkg
// Shared types, constants and the alphabet lookup for the URL-safe base64
// encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ube64_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned GroupChars = 4;

  localparam logic [7:0] PadChar = 8'h2d;  // '-'

  // position of the next byte within its group of three
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_e;

  // one accepted byte worth of output characters
  typedef struct packed {
    logic [GroupChars-1:0][7:0] chars;     // chars[0] goes out first
    logic [1:0]                 last_idx;  // index of the final char of this word
    logic                       fin;       // word closes the message
  } job_t;

  // 6-bit value to ASCII: A-Z, a-z, 0-9, '.', '_'
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] c;
    c = 8'h5f;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2e;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/ube64_if.sv -----
// ----------------------------------------------------------------------------
// ube64_if
// Valid/ready channel interfaces for raw bytes and encoded characters.
// ----------------------------------------------------------------------------
`default_nettype none

interface ube64_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_final;

  modport source (output valid, output data_byte, output is_final, input ready);
  modport sink   (input valid, input data_byte, input is_final, output ready);
endinterface

interface ube64_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

`default_nettype wire

// ----- hdl/ube64_front.sv -----
// ----------------------------------------------------------------------------
// ube64_front
// Accepts bytes, tracks group phase and carry bits, and builds the word of
// characters each byte produces.
// ----------------------------------------------------------------------------
`default_nettype none

module ube64_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  ube64_byte_if.sink          in_i,
  input  wire logic           full_i,
  output logic                push_o,
  output ube64_pkg::job_t     job_o
);
  import ube64_pkg::*;

  phase_e     phase_q, phase_d;
  logic [3:0] carry_q, carry_d;
  logic [7:0] b;
  logic       fin;
  logic       take;

  assign b      = in_i.data_byte;
  assign fin    = in_i.is_final;
  assign in_i.ready = !full_i;
  assign take   = in_i.valid && !full_i;
  assign push_o = take;

  always_comb begin
    job_o.chars    = '{default: PadChar};
    job_o.fin      = fin;
    job_o.last_idx = 2'd0;
    phase_d        = phase_q;
    carry_d        = carry_q;
    case (phase_q)
      PH_SECOND: begin
        job_o.chars[0] = enc_char({carry_q[1:0], b[7:4]});
        if (fin) begin
          job_o.chars[1] = enc_char({b[3:0], 2'b00});
          job_o.last_idx = 2'd2;
        end
        carry_d = b[3:0];
        phase_d = PH_THIRD;
      end
      PH_THIRD: begin
        job_o.chars[0] = enc_char({carry_q, b[7:6]});
        job_o.chars[1] = enc_char(b[5:0]);
        job_o.last_idx = 2'd1;
        carry_d = 4'd0;
        phase_d = PH_FIRST;
      end
      default: begin
        // the unused phase code behaves as the first byte of a group
        job_o.chars[0] = enc_char(b[7:2]);
        if (fin) begin
          job_o.chars[1] = enc_char({b[1:0], 4'b0000});
          job_o.last_idx = 2'd3;
        end
        carry_d = {2'b00, b[1:0]};
        phase_d = PH_SECOND;
      end
    endcase
    if (fin) begin
      carry_d = 4'd0;
      phase_d = PH_FIRST;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      carry_q <= 4'd0;
    end else if (take) begin
      phase_q <= phase_d;
      carry_q <= carry_d;
    end
  end

  // carry holds only two bits after the first byte of a group
  a_carry_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SECOND) |-> (carry_q[3:2] == 2'b00))
    else $error("carry bits too wide after first byte");

endmodule

`default_nettype wire

// ----- hdl/ube64_fifo.sv -----
// ----------------------------------------------------------------------------
// ube64_fifo
// Short queue of character words between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ube64_fifo #(
  parameter int unsigned Depth = ube64_pkg::QueueDepth  // 2 or more
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire ube64_pkg::job_t  push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output ube64_pkg::job_t       pop_data_o,
  output logic                  empty_o
);
  import ube64_pkg::*;

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [IdxW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  function automatic logic [IdxW-1:0] wrap_inc(input logic [IdxW-1:0] p);
    return (p == IdxW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_ptr_q <= wrap_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= wrap_inc(rd_ptr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count exceeds depth");

  a_ptr_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o || full_o) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ----- hdl/ube64_back.sv -----
// ----------------------------------------------------------------------------
// ube64_back
// Walks each queued word one character per cycle, while the receiver is ready, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ube64_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ube64_pkg::job_t  job_i,
  input  wire logic             empty_i,
  output logic                  pop_o,
  ube64_char_if.source          out_o
);
  import ube64_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  logic [7:0] char_q, char_d;
  logic       last_q, last_d;
  logic       load;
  logic       word_end;

  assign load     = !vld_q || out_o.ready;
  assign word_end = (idx_q == job_i.last_idx);

  always_comb begin
    idx_d  = idx_q;
    vld_d  = vld_q;
    char_d = char_q;
    last_d = last_q;
    pop_o  = 1'b0;
    if (load) begin
      vld_d  = !empty_i;
      char_d = job_i.chars[idx_q];
      last_d = job_i.fin && word_end;
      if (!empty_i) begin
        if (word_end) begin
          idx_d = 2'd0;
          pop_o = 1'b1;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_o.valid    = vld_q;
  assign out_o.out_char = char_q;
  assign out_o.out_last = last_q;

  // a word in progress stays at the head of the queue until its last char
  a_idx_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 2'd0) |-> !empty_i)
    else $error("character index set with no queued word");

endmodule

`default_nettype wire

// ----- hdl/url_safe_base64_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// url_safe_base64_encoder_unit
// URL-safe base64 encoder: each accepted byte becomes one word of characters, sent out one character at a time.
//
// Input channel in_i carries a message byte and a flag on its final byte.
// Output channel out_o carries ASCII characters (A-Z a-z 0-9 . _) and the
// '-' pad; out_last marks the final character of the message.
// A byte yields 1 or 2 characters mid-message; the final byte yields the
// rest of its group padded to four characters (2 to 4 characters).
// A byte's first character is registered in the word queue and then in the
// output register before it is valid. The output register sends one
// character per cycle while the receiver is ready. The input keeps
// accepting while the word queue has room, so bytes are taken while
// earlier characters are still waiting.
// Reset clears the group phase, carry bits, queue and output valid flag.
// When the receiver stalls, the output register holds its character and
// the queue fills; in_i.ready drops once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module url_safe_base64_encoder_unit #(
  parameter int unsigned FifoDepth = ube64_pkg::QueueDepth
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  ube64_byte_if.sink   in_i,
  ube64_char_if.source out_o
);
  import ube64_pkg::*;

  job_t push_job, head_job;
  logic push, full, pop, empty;

  ube64_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  ube64_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (head_job),
    .empty_o     (empty)
  );

  ube64_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (head_job),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire
